// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers. Define NO_ASSERTIONS to drop them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Implication checked in the same cycle.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the following cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- sv/bbsp_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bbsp_pkg
// Shared constants and types of the block stream parser.
// ---------------------------------------------------------------------------
package bbsp_pkg;

    localparam int NUM_SIGNATURES_DEF      = 3;
    localparam int SLOTS_PER_SIGNATURE_DEF = 5;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int CNT_W    = 3;
    localparam int KIND_W   = 2;
    localparam int PHASE_W  = 3;
    localparam int REPORT_N = 3;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'haa;
    localparam logic [WORD_W-1:0] FRAME_MARK  = 16'haa55;

    localparam logic [PHASE_W-1:0] PH_SEARCH = 3'd0;
    localparam logic [PHASE_W-1:0] PH_CHECK  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SIG    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_X      = 3'd3;
    localparam logic [PHASE_W-1:0] PH_Y      = 3'd4;
    localparam logic [PHASE_W-1:0] PH_WIDTH  = 3'd5;
    localparam logic [PHASE_W-1:0] PH_HEIGHT = 3'd6;

    localparam logic [KIND_W-1:0] KIND_STORED  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COMMIT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DROPPED = 2'd3;

    typedef struct packed {
        logic clear;
        logic bump;
    } tally_ctrl_t;

    typedef struct packed {
        logic                             ok;
        logic [CNT_W-1:0]                 slot;
        logic [REPORT_N-1:0][CNT_W-1:0]   counts;
    } tally_stat_t;

endpackage

// ----- sv/blob_block_stream_parser.sv -----
`timescale 1ns / 1ps
// Latency: a result appears on m_ the cycle after the byte that completes it is taken.
// Throughput: one byte per cycle; s_ready drops only while a result waits on m_ready.
// The running checksum is summed word by word, so the last byte needs one add and compare.
// Reset (aresetn low, synchronous) returns the parser to sync search and clears
// the frame tallies and the output valid.
// ---------------------------------------------------------------------------
// blob_block_stream_parser
// Sync-word record parser: assembles block words from a byte stream, checks
// the checksum and reports stored, dropped and bad blocks and frame commits.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module blob_block_stream_parser #(
    parameter int NUM_SIGNATURES      = bbsp_pkg::NUM_SIGNATURES_DEF,
    parameter int SLOTS_PER_SIGNATURE = bbsp_pkg::SLOTS_PER_SIGNATURE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bbsp_pkg::BYTE_W-1:0]   s_rx_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bbsp_pkg::KIND_W-1:0]   m_kind,
    output logic [bbsp_pkg::WORD_W-1:0]   m_object_signature,
    output logic [bbsp_pkg::CNT_W-1:0]    m_slot_index,
    output logic [bbsp_pkg::WORD_W-1:0]   m_x_pos,
    output logic [bbsp_pkg::WORD_W-1:0]   m_y_pos,
    output logic [bbsp_pkg::WORD_W-1:0]   m_box_width,
    output logic [bbsp_pkg::WORD_W-1:0]   m_box_height,
    output logic [bbsp_pkg::CNT_W-1:0]    m_first_sig_count,
    output logic [bbsp_pkg::CNT_W-1:0]    m_second_sig_count,
    output logic [bbsp_pkg::CNT_W-1:0]    m_third_sig_count
);

    logic [bbsp_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic                         half_reg, half_next;
    logic [bbsp_pkg::BYTE_W-1:0]  low_reg, low_next;
    logic [bbsp_pkg::WORD_W-1:0]  check_reg, check_next;
    logic [bbsp_pkg::WORD_W-1:0]  sig_reg, sig_next;
    logic [bbsp_pkg::WORD_W-1:0]  x_reg, x_next;
    logic [bbsp_pkg::WORD_W-1:0]  y_reg, y_next;
    logic [bbsp_pkg::WORD_W-1:0]  width_reg, width_next;
    logic [bbsp_pkg::WORD_W-1:0]  sum_reg, sum_next;
    logic                         good_reg, good_next;
    logic                         err_reg, err_next;

    logic                         out_valid_reg, out_valid_next;
    logic [bbsp_pkg::KIND_W-1:0]  kind_reg, kind_next;
    logic [bbsp_pkg::WORD_W-1:0]  osig_reg, osig_next;
    logic [bbsp_pkg::CNT_W-1:0]   slot_reg, slot_next;
    logic [bbsp_pkg::WORD_W-1:0]  ox_reg, ox_next;
    logic [bbsp_pkg::WORD_W-1:0]  oy_reg, oy_next;
    logic [bbsp_pkg::WORD_W-1:0]  ow_reg, ow_next;
    logic [bbsp_pkg::WORD_W-1:0]  oh_reg, oh_next;
    logic [bbsp_pkg::CNT_W-1:0]   c1_reg, c1_next;
    logic [bbsp_pkg::CNT_W-1:0]   c2_reg, c2_next;
    logic [bbsp_pkg::CNT_W-1:0]   c3_reg, c3_next;

    logic                         acc;
    logic                         emit;
    logic [bbsp_pkg::WORD_W-1:0]  word;
    logic [bbsp_pkg::WORD_W-1:0]  total;
    bbsp_pkg::tally_ctrl_t        tctrl;
    bbsp_pkg::tally_stat_t        tstat;

    bbsp_tally #(
        .NUM_SIGNATURES      (NUM_SIGNATURES),
        .SLOTS_PER_SIGNATURE (SLOTS_PER_SIGNATURE)
    ) u_tally (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .sig_word (sig_reg),
        .ctrl     (tctrl),
        .stat     (tstat)
    );

    assign s_ready = !out_valid_reg || m_ready;
    assign acc     = s_valid && s_ready;
    assign word    = {s_rx_byte, low_reg};
    assign total   = sum_reg + word;

    always_comb begin
        phase_next = phase_reg;
        half_next  = half_reg;
        low_next   = low_reg;
        check_next = check_reg;
        sig_next   = sig_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        width_next = width_reg;
        sum_next   = sum_reg;
        good_next  = good_reg;
        err_next   = err_reg;
        tctrl      = '0;
        emit       = 1'b0;
        kind_next  = kind_reg;
        osig_next  = '0;
        slot_next  = '0;
        ox_next    = '0;
        oy_next    = '0;
        ow_next    = '0;
        oh_next    = '0;
        c1_next    = '0;
        c2_next    = '0;
        c3_next    = '0;

        if (acc) begin
            case (phase_reg)
                bbsp_pkg::PH_SEARCH: begin
                    if (s_rx_byte != '0) begin
                        if (!half_reg) begin
                            half_next = (s_rx_byte == bbsp_pkg::SYNC_FIRST);
                        end else if (s_rx_byte == bbsp_pkg::SYNC_SECOND) begin
                            phase_next = bbsp_pkg::PH_CHECK;
                            half_next  = 1'b0;
                        end else begin
                            half_next = (s_rx_byte == bbsp_pkg::SYNC_FIRST);
                        end
                    end
                end
                bbsp_pkg::PH_CHECK, bbsp_pkg::PH_SIG, bbsp_pkg::PH_X,
                bbsp_pkg::PH_Y, bbsp_pkg::PH_WIDTH, bbsp_pkg::PH_HEIGHT: begin
                    if (!half_reg) begin
                        low_next  = s_rx_byte;
                        half_next = 1'b1;
                    end else begin
                        half_next = 1'b0;
                        case (phase_reg)
                            bbsp_pkg::PH_CHECK: begin
                                if (word == bbsp_pkg::FRAME_MARK) begin
                                    if (good_reg && !err_reg) begin
                                        emit      = 1'b1;
                                        kind_next = bbsp_pkg::KIND_COMMIT;
                                        c1_next   = tstat.counts[0];
                                        c2_next   = tstat.counts[1];
                                        c3_next   = tstat.counts[2];
                                    end
                                    good_next   = 1'b0;
                                    err_next    = 1'b0;
                                    tctrl.clear = 1'b1;
                                end else begin
                                    check_next = word;
                                    phase_next = bbsp_pkg::PH_SIG;
                                end
                            end
                            bbsp_pkg::PH_SIG: begin
                                sig_next   = word;
                                sum_next   = word;
                                phase_next = bbsp_pkg::PH_X;
                            end
                            bbsp_pkg::PH_X: begin
                                x_next     = word;
                                sum_next   = total;
                                phase_next = bbsp_pkg::PH_Y;
                            end
                            bbsp_pkg::PH_Y: begin
                                y_next     = word;
                                sum_next   = total;
                                phase_next = bbsp_pkg::PH_WIDTH;
                            end
                            bbsp_pkg::PH_WIDTH: begin
                                width_next = word;
                                sum_next   = total;
                                phase_next = bbsp_pkg::PH_HEIGHT;
                            end
                            default: begin
                                // height word closes the block
                                phase_next = bbsp_pkg::PH_SEARCH;
                                emit       = 1'b1;
                                osig_next  = sig_reg;
                                ox_next    = x_reg;
                                oy_next    = y_reg;
                                ow_next    = width_reg;
                                oh_next    = word;
                                if (total != check_reg) begin
                                    err_next  = 1'b1;
                                    kind_next = bbsp_pkg::KIND_ERROR;
                                end else begin
                                    good_next = 1'b1;
                                    if (tstat.ok) begin
                                        kind_next  = bbsp_pkg::KIND_STORED;
                                        slot_next  = tstat.slot;
                                        tctrl.bump = 1'b1;
                                    end else begin
                                        kind_next = bbsp_pkg::KIND_DROPPED;
                                    end
                                end
                            end
                        endcase
                    end
                end
                default: begin
                    phase_next = bbsp_pkg::PH_SEARCH;
                end
            endcase
        end

        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= bbsp_pkg::PH_SEARCH;
            half_reg      <= 1'b0;
            good_reg      <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            half_reg      <= half_next;
            good_reg      <= good_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        low_reg   <= low_next;
        check_reg <= check_next;
        sig_reg   <= sig_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        width_reg <= width_next;
        sum_reg   <= sum_next;
        if (emit) begin
            kind_reg <= kind_next;
            osig_reg <= osig_next;
            slot_reg <= slot_next;
            ox_reg   <= ox_next;
            oy_reg   <= oy_next;
            ow_reg   <= ow_next;
            oh_reg   <= oh_next;
            c1_reg   <= c1_next;
            c2_reg   <= c2_next;
            c3_reg   <= c3_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_kind             = kind_reg;
    assign m_object_signature = osig_reg;
    assign m_slot_index       = slot_reg;
    assign m_x_pos            = ox_reg;
    assign m_y_pos            = oy_reg;
    assign m_box_width        = ow_reg;
    assign m_box_height       = oh_reg;
    assign m_first_sig_count  = c1_reg;
    assign m_second_sig_count = c2_reg;
    assign m_third_sig_count  = c3_reg;

    `ASSERT_NEXT(a_height_emits, aclk, aresetn, acc && half_reg && phase_reg == bbsp_pkg::PH_HEIGHT, m_valid, "completed block gave no result")
    `ASSERT_SAME(a_slot_bound, aclk, aresetn, m_valid && m_kind == bbsp_pkg::KIND_STORED, m_slot_index < bbsp_pkg::CNT_W'(SLOTS_PER_SIGNATURE), "stored slot out of range")
    `ASSERT_SAME(a_commit_clean, aclk, aresetn, m_valid && m_kind == bbsp_pkg::KIND_COMMIT, m_object_signature == '0 && m_slot_index == '0, "commit carries block fields")
    `ASSERT_NEXT(a_search_after_block, aclk, aresetn, acc && half_reg && phase_reg == bbsp_pkg::PH_HEIGHT, phase_reg == bbsp_pkg::PH_SEARCH && !half_reg, "parser did not resync after block")

endmodule

// ----- sv/bbsp_tally.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bbsp_tally
// Per-signature block counts of the current frame: slot lookup, bump, clear.
// ---------------------------------------------------------------------------
module bbsp_tally #(
    parameter int NUM_SIGNATURES      = bbsp_pkg::NUM_SIGNATURES_DEF,
    parameter int SLOTS_PER_SIGNATURE = bbsp_pkg::SLOTS_PER_SIGNATURE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [bbsp_pkg::WORD_W-1:0]   sig_word,
    input  bbsp_pkg::tally_ctrl_t         ctrl,
    output bbsp_pkg::tally_stat_t         stat
);

    logic [bbsp_pkg::CNT_W-1:0] cnt_reg  [NUM_SIGNATURES];
    logic [bbsp_pkg::CNT_W-1:0] cnt_next [NUM_SIGNATURES];
    logic [NUM_SIGNATURES-1:0]  hit;
    logic [bbsp_pkg::CNT_W-1:0] sel_cnt;
    logic                       room;
    logic [bbsp_pkg::REPORT_N-1:0][bbsp_pkg::CNT_W-1:0] rep_cnt;

    always_comb begin
        sel_cnt = '0;
        for (int i = 0; i < NUM_SIGNATURES; i++) begin
            hit[i] = (sig_word == bbsp_pkg::WORD_W'(i + 1));
            if (hit[i]) begin
                sel_cnt = sel_cnt | cnt_reg[i];
            end
        end
        room        = (sel_cnt < bbsp_pkg::CNT_W'(SLOTS_PER_SIGNATURE));
        stat.ok     = (|hit) && room;
        stat.slot   = sel_cnt;
        stat.counts = rep_cnt;
        for (int i = 0; i < NUM_SIGNATURES; i++) begin
            if (ctrl.clear) begin
                cnt_next[i] = '0;
            end else if (ctrl.bump && hit[i] && room) begin
                cnt_next[i] = cnt_reg[i] + 1'b1;
            end else begin
                cnt_next[i] = cnt_reg[i];
            end
        end
    end

    for (genvar j = 0; j < bbsp_pkg::REPORT_N; j++) begin : g_report
        if (j < NUM_SIGNATURES) begin : g_used
            assign rep_cnt[j] = cnt_reg[j];
        end else begin : g_unused
            assign rep_cnt[j] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_SIGNATURES; i++) begin
            if (!aresetn) begin
                cnt_reg[i] <= '0;
            end else begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

endmodule
